// File: design/srrw_pkg.sv
// Shared types and constants for the selective repeat receive window.
// Holds the segment and response item structs and the status codes.
// No dependencies.
`default_nettype none

package srrw_pkg;

  // Default number of sequence slots in one receive window.
  localparam int WINDOW_DEFAULT = 256;

  // Classification of one segment.
  typedef enum logic [2:0] {
    STAT_CORRUPT  = 3'd0,
    STAT_IN_ORDER = 3'd1,
    STAT_SACKED   = 3'd2,
    STAT_DROPPED  = 3'd3,
    STAT_CLOSED   = 3'd4
  } status_t;

  // One arriving segment.
  typedef struct packed {
    logic [31:0] seq_number;
    logic        checksum_good;
    logic        fin_flag;
  } seg_item_t;

  // One acknowledgement and release result.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ack_number;
    logic [31:0] sack_number;
    logic        fin_ack;
    logic        release_valid;
    logic [31:0] release_first;
    logic [31:0] release_last;
  } rsp_item_t;

endpackage

`default_nettype wire

// File: design/srrw_first_missing.sv
// Priority encoder that finds the lowest clear bit of the window bitmap.
// Returns the bitmap width when every bit is set. No package dependency.
`default_nettype none

module srrw_first_missing #(
  parameter int WIDTH = 256
) (
  input  wire logic [WIDTH-1:0]         bits,
  output logic [$clog2(WIDTH+1)-1:0]    index
);

  localparam int IndexW = $clog2(WIDTH + 1);

  // Scan from the top so that the lowest clear bit wins.
  always_comb begin
    index = IndexW'(WIDTH);
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        index = IndexW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/srrw_core.sv
// Window state and segment classification for the selective repeat receiver.
// Depends on srrw_pkg and srrw_first_missing.
`default_nettype none

module srrw_core #(
  parameter int WINDOW = srrw_pkg::WINDOW_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire srrw_pkg::seg_item_t item,
  output srrw_pkg::rsp_item_t      result
);

  localparam int SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MissW = $clog2(WINDOW + 1);

  // Window state.
  logic [WINDOW-1:0] received_map, received_map_next;
  logic [31:0]       next_expected, next_expected_next;
  logic [31:0]       window_start, window_start_next;
  logic              fin_seen, fin_seen_next;
  logic              closed, closed_next;

  logic [31:0]       offset;
  logic              in_window;
  logic [SlotW-1:0]  slot;
  logic              in_order;
  logic [WINDOW-1:0] filled_map;
  logic [MissW-1:0]  missing;

  // Offset of the segment from the first slot of the window.
  assign offset    = item.seq_number - window_start - 32'd1;
  assign in_window = offset < 32'(WINDOW);
  assign slot      = offset[SlotW-1:0];
  assign in_order  = (item.seq_number == next_expected) && in_window;

  // Bitmap with the arriving slot and every slot below it marked.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      filled_map[i] = received_map[i] | (32'(i) <= 32'(slot));
    end
  end

  srrw_first_missing #(
    .WIDTH (WINDOW)
  ) u_first_missing (
    .bits  (filled_map),
    .index (missing)
  );

  // Classify the segment and work out the next window state.
  always_comb begin
    received_map_next  = received_map;
    next_expected_next = next_expected;
    window_start_next  = window_start;
    fin_seen_next      = fin_seen;
    closed_next        = closed;

    result               = '0;
    result.sack_number   = next_expected - 32'd1;

    if (closed) begin
      result.status  = srrw_pkg::STAT_CLOSED;
      result.fin_ack = 1'b1;
    end else if (!item.checksum_good) begin
      result.status = srrw_pkg::STAT_CORRUPT;
    end else begin
      fin_seen_next = fin_seen | item.fin_flag;
      if (in_order) begin
        received_map_next[slot] = 1'b1;
        next_expected_next      = window_start + 32'(missing) + 32'd1;
        result.status           = srrw_pkg::STAT_IN_ORDER;
        result.sack_number      = item.seq_number;
        result.fin_ack          = fin_seen_next;
        if (fin_seen_next) begin
          // Final release of whatever is contiguous, then close.
          result.release_valid = 1'b1;
          result.release_first = window_start + 32'd1;
          result.release_last  = next_expected_next - 32'd1;
          closed_next          = 1'b1;
        end else if (32'(missing) == 32'(WINDOW)) begin
          // Whole window received: release it and open the next one.
          result.release_valid = 1'b1;
          result.release_first = window_start + 32'd1;
          result.release_last  = window_start + 32'(WINDOW);
          window_start_next    = window_start + 32'(WINDOW);
          received_map_next    = '0;
        end
      end else if (in_window) begin
        received_map_next[slot] = 1'b1;
        result.status           = srrw_pkg::STAT_SACKED;
        result.sack_number      = item.seq_number;
        result.fin_ack          = fin_seen_next;
      end else if (offset[31]) begin
        // Below the window: acknowledged again but not stored.
        result.status      = srrw_pkg::STAT_SACKED;
        result.sack_number = item.seq_number;
        result.fin_ack     = fin_seen_next;
      end else begin
        result.status = srrw_pkg::STAT_DROPPED;
      end
    end

    result.ack_number = next_expected_next - 32'd1;
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      received_map  <= '0;
      next_expected <= 32'd1;
      window_start  <= 32'd0;
      fin_seen      <= 1'b0;
      closed        <= 1'b0;
    end else if (fire) begin
      received_map  <= received_map_next;
      next_expected <= next_expected_next;
      window_start  <= window_start_next;
      fin_seen      <= fin_seen_next;
      closed        <= closed_next;
    end
  end

endmodule

`default_nettype wire

// File: design/selective_repeat_receive_window.sv
// Selective repeat receive window with selective acknowledgement.
// Segments wait in the input register and responses in the response register.
// Throughput: one segment per cycle while rsp_stall is low; the window bitmap, its
// lowest-missing-slot encoder and the state update all work on the input register.
// Reset: synchronous; clears the bitmap, sets the next expected number to 1,
// and empties the input and response registers. Depends on srrw_pkg, srrw_core.
`default_nettype none

module selective_repeat_receive_window #(
  parameter int WINDOW = srrw_pkg::WINDOW_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                seg_valid,
  output logic                     seg_stall,
  input  wire srrw_pkg::seg_item_t seg,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output srrw_pkg::rsp_item_t      rsp
);

  logic                s1_valid;
  srrw_pkg::seg_item_t s1_item;
  logic                fire;
  logic                accept;
  srrw_pkg::rsp_item_t result;

  // The held item is processed whenever the response register is free or draining.
  assign fire      = s1_valid && (!rsp_valid || !rsp_stall);
  assign seg_stall = s1_valid && !fire;
  assign accept    = seg_valid && !seg_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= seg;
    end
  end

  srrw_core #(
    .WINDOW (WINDOW)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (result)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_selective_repeat_receive_window.sv
// Self-checking testbench for the selective repeat receive window.
// A scoreboard class predicts each response from the accepted segments and checks
// every response against it. Depends on srrw_pkg and selective_repeat_receive_window.
module tb_selective_repeat_receive_window;
  import srrw_pkg::*;

  localparam int WIN          = WINDOW_DEFAULT;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      seg_valid = 1'b0;
  logic      seg_stall;
  seg_item_t seg       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  int          cycle_count = 0;
  int          burst_left  = 0;
  int unsigned rx_phase    = 0;
  int unsigned stall_mode  = 0;

  // Predicts the acknowledgement for each accepted segment and checks responses.
  class srrw_scoreboard;
    logic [WIN-1:0] slot_map;
    logic [31:0]    next_expected;
    logic [31:0]    window_base;
    logic           fin_seen;
    logic           closed;
    rsp_item_t      acks_due[$];
    int             errors;
    int             checked;
    int             releases;
    int             tally[5];

    function new();
      slot_map      = '0;
      next_expected = 32'd1;
      window_base   = 32'd0;
      fin_seen      = 1'b0;
      closed        = 1'b0;
      errors        = 0;
      checked       = 0;
      releases      = 0;
      foreach (tally[n]) tally[n] = 0;
    endfunction

    function int waiting();
      return acks_due.size();
    endfunction

    // Work out the response for one accepted segment and queue it.
    function void note_segment(seg_item_t s);
      rsp_item_t   want;
      logic [31:0] off;
      int unsigned m;
      want = '0;
      if (closed) begin
        want.status      = STAT_CLOSED;
        want.sack_number = next_expected - 32'd1;
        want.fin_ack     = 1'b1;
      end else if (!s.checksum_good) begin
        want.status      = STAT_CORRUPT;
        want.sack_number = next_expected - 32'd1;
      end else begin
        off = s.seq_number - window_base - 32'd1;
        if (s.fin_flag) fin_seen = 1'b1;
        if (s.seq_number == next_expected && off < WIN) begin
          // In order: advance to the lowest slot still missing.
          slot_map[off] = 1'b1;
          m = off + 1;
          while (m < WIN && slot_map[m]) m++;
          next_expected    = window_base + m + 32'd1;
          want.status      = STAT_IN_ORDER;
          want.sack_number = s.seq_number;
          want.fin_ack     = fin_seen;
          if (fin_seen) begin
            want.release_valid = 1'b1;
            want.release_first = window_base + 32'd1;
            want.release_last  = next_expected - 32'd1;
            closed             = 1'b1;
          end else if (m == WIN) begin
            want.release_valid = 1'b1;
            want.release_first = window_base + 32'd1;
            want.release_last  = window_base + WIN;
            window_base        = window_base + WIN;
            slot_map           = '0;
          end
        end else if (off < WIN) begin
          slot_map[off]    = 1'b1;
          want.status      = STAT_SACKED;
          want.sack_number = s.seq_number;
          want.fin_ack     = fin_seen;
        end else if (off[31]) begin
          // Below the window: acknowledged again but not stored.
          want.status      = STAT_SACKED;
          want.sack_number = s.seq_number;
          want.fin_ack     = fin_seen;
        end else begin
          want.status      = STAT_DROPPED;
          want.sack_number = next_expected - 32'd1;
        end
      end
      want.ack_number = next_expected - 32'd1;
      tally[want.status]++;
      if (want.release_valid) releases++;
      acks_due.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one response with the oldest prediction.
    function void check_response(rsp_item_t got);
      rsp_item_t want;
      if (acks_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected response: expected none, actual status %0d ack %0h",
                 $time, got.status, got.ack_number);
        return;
      end
      want = acks_due.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("ack_number", want.ack_number, got.ack_number);
      compare_field("sack_number", want.sack_number, got.sack_number);
      compare_field("fin_ack", want.fin_ack, got.fin_ack);
      compare_field("release_valid", want.release_valid, got.release_valid);
      compare_field("release_first", want.release_first, got.release_first);
      compare_field("release_last", want.release_last, got.release_last);
    endfunction
  endclass

  srrw_scoreboard board = new();

  selective_repeat_receive_window #(.WINDOW(WIN)) dut (
    .clk      (clk),
    .rst      (rst),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .seg      (seg),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #6 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
               board.waiting());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Response side: check accepted items and stall in changing modes.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) board.check_response(rsp);
      rx_phase++;
      if (rx_phase % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 2) == 0);
        2: rsp_stall <= ((rx_phase % 5) < 3);
        default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  function automatic seg_item_t make_seg(logic [31:0] seq, logic good, logic fin);
    seg_item_t s;
    s.seq_number    = seq;
    s.checksum_good = good;
    s.fin_flag      = fin;
    return s;
  endfunction

  // Offer one segment, in bursts with random gaps, and hold it until accepted.
  task automatic send_seg(input seg_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        seg_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    seg_valid <= 1'b1;
    seg       <= item;
    do @(posedge clk); while (seg_stall !== 1'b0);
    board.note_segment(item);
    burst_left--;
  endtask

  // Hold off the sender until every predicted response has come back.
  task automatic wait_drained();
    seg_valid <= 1'b0;
    burst_left = 0;
    while (board.waiting() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] order[WIN];
    logic [31:0] base;
    logic [31:0] tmp;
    int          i;
    int          j;
    int          k;
    int unsigned disorder;
    int unsigned last_slot;
    logic        full;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: window edges, wrap of the offset, duplicates and corruption.
    send_seg(make_seg(32'd1, 1'b1, 1'b0));
    send_seg(make_seg(32'd3, 1'b1, 1'b0));
    send_seg(make_seg(32'd3, 1'b1, 1'b0));
    send_seg(make_seg(32'd2, 1'b1, 1'b0));
    send_seg(make_seg(32'd0, 1'b1, 1'b0));
    send_seg(make_seg(32'hFFFF_FFFF, 1'b1, 1'b0));
    send_seg(make_seg(WIN, 1'b1, 1'b0));
    send_seg(make_seg(WIN + 1, 1'b1, 1'b0));
    send_seg(make_seg(32'h8000_0000, 1'b1, 1'b0));
    send_seg(make_seg(32'h8000_0001, 1'b1, 1'b0));
    send_seg(make_seg(32'h7FFF_FFFF, 1'b1, 1'b0));
    send_seg(make_seg(32'd4, 1'b0, 1'b1));
    send_seg(make_seg(32'hFFFF_FFFF, 1'b0, 1'b0));
    send_seg(make_seg(32'd4, 1'b1, 1'b0));
    send_seg(make_seg(32'd5, 1'b0, 1'b1));
    wait_drained();

    // Random: fill whole windows in varying disorder, with noise mixed in.
    for (k = 0; k < 4; k++) begin
      base = k * WIN;
      case ($urandom_range(0, 3))
        0: disorder = 0;
        1: disorder = 3;
        2: disorder = 24;
        default: disorder = WIN - 1;
      endcase
      for (i = 0; i < WIN; i++) order[i] = base + i + 1;
      for (i = 0; i < WIN; i++) begin
        j = i + $urandom_range(0, disorder);
        if (j > WIN - 1) j = WIN - 1;
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (i = 0; i < WIN; i++) begin
        if ($urandom_range(0, 99) < 13) begin
          case ($urandom_range(0, 4))
            0: send_seg(make_seg($urandom, 1'b0, 1'($urandom_range(0, 1))));
            1: send_seg(make_seg(base + $urandom_range(1, WIN), 1'b1, 1'b0));
            2: send_seg(make_seg(base + WIN + $urandom_range(1, 4), 1'b1, 1'b0));
            3: send_seg(make_seg(base - $urandom_range(0, 3), 1'b1, 1'b0));
            default: send_seg(make_seg($urandom, 1'b1, 1'b0));
          endcase
        end
        send_seg(make_seg(order[i], 1'b1, 1'b0));
      end
      if (k == 1) wait_drained();
    end

    // Close the transfer: either a full window ending on a fin, or a fin seen
    // beyond the window followed by the missing in-order segment.
    base      = 4 * WIN;
    full      = 1'($urandom_range(0, 1));
    last_slot = full ? WIN : $urandom_range(8, 120);
    for (i = 0; i < last_slot - 1; i++) order[i] = base + i + 2;
    for (i = 0; i < last_slot - 1; i++) begin
      j = i + $urandom_range(0, 8);
      if (j > last_slot - 2) j = last_slot - 2;
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < last_slot - 1; i++) send_seg(make_seg(order[i], 1'b1, 1'b0));
    if (full) begin
      send_seg(make_seg(base + 1, 1'b1, 1'b1));
    end else begin
      send_seg(make_seg(base + WIN + 5, 1'b1, 1'b1));
      send_seg(make_seg(base + 1, 1'b1, 1'b0));
    end

    // Anything after close is answered but changes nothing.
    for (i = 0; i < 12; i++) begin
      send_seg(make_seg($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses: %0d in order, %0d sacked, %0d dropped, %0d corrupted,",
             board.checked, board.tally[STAT_IN_ORDER], board.tally[STAT_SACKED],
             board.tally[STAT_DROPPED], board.tally[STAT_CORRUPT]);
    $display("%0d after close; %0d ranges released, closing window %0s.",
             board.tally[STAT_CLOSED], board.releases, full ? "full" : "partial");
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
